/* sv/pmsc_pkg.sv */
// pmsc_pkg: shared types and constants for the principal minor sign checker.
// Holds default sizes, fixed field widths, register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package pmsc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DIMENSION_DEF = 32;
    localparam int MAX_MINOR_DEF     = 5;
    localparam int ENTRY_BITS_DEF    = 8;

    // Working value and numerator widths
    localparam int VAL_W  = 64;
    localparam int NUM_W  = 128;
    localparam int HALF_W = 32;

    // Fixed port and register widths
    localparam int ROW_W      = 5;
    localparam int DIM_W      = 6;
    localparam int MINOR_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int CNT_W      = 8;
    localparam int MCNT_W     = 4;
    localparam int DCNT_W     = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGEST_MINOR = 2'd1;

    // Register reset values
    localparam logic [DIM_W-1:0]   DIMENSION_RST     = 6'd32;
    localparam logic [MINOR_W-1:0] LARGEST_MINOR_RST = 3'd5;

    // Multiplier steps: four partial products per product, two products
    localparam logic [MCNT_W-1:0] MUL_LAST = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIZE,
        ST_LOAD,
        ST_DRAIN,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_OP_RD,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_END,
        ST_WRITE,
        ST_LAST_RD,
        ST_LAST_CHK,
        ST_NEXT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* sv/principal_minor_sign_check_top.sv */
// principal_minor_sign_check_top: loads a square matrix, then tests every principal
// minor up to a set size for a negative determinant by fraction-free elimination.
// Depends on pmsc_pkg (constants, state type).
//
//  channel   | signals                                              | direction
//  ----------+------------------------------------------------------+----------
//  entry     | start, busy, row_index, column_index, entry_value,   | in
//            | last_entry                                           |
//  result    | done, negative_found                                 | out
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data            | in
//
// An entry word is taken on any edge with start high and busy low: one per cycle while
// loading. A word with last_entry set starts the minor search; busy then stays high until
// the cycle after done. Each minor size is first checked against the limits. Per minor
// of size s: gather it from the matrix RAM (one read per element plus a drain step),
// read and test each pivot candidate, and per eliminated element do the operand reads,
// the multiply (one 32x32 multiplier, four partial products per product), one setup
// step, after the first pivot step a radix-2 division and a sign fix-up, and one write;
// then read and test the final element and step to the next subset. The search ends at
// the first negative minor or after the last subset; done is one cycle. Results cannot
// be held off. The configuration port is always ready.
`default_nettype none

module principal_minor_sign_check_top #(
    parameter int MAX_DIMENSION = pmsc_pkg::MAX_DIMENSION_DEF,
    parameter int MAX_MINOR     = pmsc_pkg::MAX_MINOR_DEF,
    parameter int ENTRY_BITS    = pmsc_pkg::ENTRY_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [pmsc_pkg::ROW_W-1:0]       row_index,
    input  wire logic [pmsc_pkg::ROW_W-1:0]       column_index,
    input  wire logic signed [ENTRY_BITS-1:0]     entry_value,
    input  wire logic                             last_entry,
    output logic                                  done,
    output logic                                  negative_found,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [pmsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pmsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W    = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int ST_DEPTH = 1 << (2 * IDX_W);
    localparam int MW       = (MAX_MINOR > 1) ? $clog2(MAX_MINOR) : 1;
    localparam int SW       = $clog2(MAX_MINOR + 2);
    localparam int WK_DEPTH = MAX_MINOR * MAX_MINOR;
    localparam int WAW      = (WK_DEPTH > 1) ? $clog2(WK_DEPTH) : 1;
    localparam int CW       = pmsc_pkg::CNT_W;
    localparam int VW       = pmsc_pkg::VAL_W;
    localparam int NW       = pmsc_pkg::NUM_W;
    localparam int HW       = pmsc_pkg::HALF_W;
    localparam logic [CW-1:0] N_MAX = CW'(MAX_DIMENSION);
    localparam logic [CW-1:0] M_MAX = CW'(MAX_MINOR);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    pmsc_pkg::state_t state_reg, state_next;

    logic [pmsc_pkg::DIM_W-1:0]   dim_reg;
    logic [pmsc_pkg::MINOR_W-1:0] minor_reg;

    logic [SW-1:0] sz_reg, li_reg, lj_reg, i_reg, j_reg, k_reg, p_reg;
    logic [1:0]    op_reg;
    logic [pmsc_pkg::MCNT_W-1:0] mcnt_reg;
    logic [pmsc_pkg::DCNT_W-1:0] dcnt_reg;
    logic          swap_reg, flag_reg, pend_vld_reg;

    logic [IDX_W-1:0] sub_reg  [MAX_MINOR];
    logic [MW-1:0]    perm_reg [MAX_MINOR];

    logic [WAW-1:0]        pend_addr_reg;
    logic [ENTRY_BITS-1:0] st_rd_reg;
    logic [VW-1:0]         wk_rd_reg;
    logic [VW-1:0]         opa_reg, opb_reg, opc_reg, pivot_reg, prev_reg, res_reg;
    logic [2*HW-1:0]       pp_reg;
    logic [1:0]            pp_sh_reg;
    logic                  pp_neg_reg;
    logic [NW-1:0]         acc_reg;
    logic [VW-1:0]         rem_reg, quo_reg, dmag_reg;
    logic                  qneg_reg;

    // matrix RAM and working RAM
    logic [ENTRY_BITS-1:0] store_mem [ST_DEPTH];
    logic [VW-1:0]         work_mem  [WK_DEPTH];

    logic                  accept;
    logic                  st_we;
    logic [2*IDX_W-1:0]    st_wa, st_ra;
    logic                  wk_we;
    logic [WAW-1:0]        wk_wa, wk_ra;
    logic [VW-1:0]         wk_wd;

    logic [CW-1:0]  n_eff, top_eff;
    logic           size_ok;
    logic [SW-1:0]  sz_m1;
    logic           last_j, last_i;

    // next subset
    logic               nx_any;
    logic [MW-1:0]      nx_t;
    logic [IDX_W-1:0]   nx_sub [MAX_MINOR];

    // multiplier and divider datapath
    logic [VW-1:0]   mx, my, mxm, mym;
    logic [HW-1:0]   mxh, myh;
    logic [NW-1:0]   term, acc_next;
    logic [NW-1:0]   nmag;
    logic [VW:0]     dsh;
    logic            dge;

    function automatic logic [WAW-1:0] wk_addr(input logic [MW-1:0] r, input logic [SW-1:0] c);
        return WAW'(int'(r) * MAX_MINOR + int'(c));
    endfunction

    assign accept = start && !busy;
    assign sz_m1  = sz_reg - SW'(1);
    assign last_j = (j_reg == sz_m1);
    assign last_i = (i_reg == sz_m1);

    // effective dimension and largest minor, clamped to the build limits
    always_comb
    begin
        n_eff   = (CW'(dim_reg) > N_MAX) ? N_MAX : CW'(dim_reg);
        top_eff = (CW'(minor_reg) > M_MAX) ? M_MAX : CW'(minor_reg);
        size_ok = (CW'(sz_reg) <= top_eff) && (CW'(sz_reg) <= n_eff);
    end

    // next subset in lexicographic order: bump the rightmost index not at its limit
    always_comb
    begin
        logic [CW-1:0] lim;
        nx_any = 1'b0;
        nx_t   = '0;
        for (int t = 0; t < MAX_MINOR; t++)
        begin
            lim = n_eff - CW'(sz_reg) + CW'(t);
            if ((t < int'(sz_reg)) && (CW'(sub_reg[t]) != lim))
            begin
                nx_any = 1'b1;
                nx_t   = MW'(t);
            end
        end
        for (int t = 0; t < MAX_MINOR; t++)
        begin
            if (t < int'(nx_t))
                nx_sub[t] = sub_reg[t];
            else
                nx_sub[t] = IDX_W'(CW'(sub_reg[nx_t]) + CW'(t - int'(nx_t) + 1));
        end
    end

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    assign st_we = accept && (32'(row_index) < MAX_DIMENSION)
                          && (32'(column_index) < MAX_DIMENSION);
    assign st_wa = {IDX_W'(row_index), IDX_W'(column_index)};
    assign st_ra = {sub_reg[li_reg[MW-1:0]], sub_reg[lj_reg[MW-1:0]]};

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_wa] <= entry_value;
        st_rd_reg <= store_mem[st_ra];
    end

    // the load fill and the element write never share a cycle
    always_comb
    begin
        wk_we = pend_vld_reg || (state_reg == pmsc_pkg::ST_WRITE);
        if (pend_vld_reg)
        begin
            wk_wa = pend_addr_reg;
            wk_wd = {{(VW-ENTRY_BITS){st_rd_reg[ENTRY_BITS-1]}}, st_rd_reg};
        end
        else
        begin
            wk_wa = wk_addr(perm_reg[i_reg[MW-1:0]], j_reg);
            wk_wd = res_reg;
        end
    end

    always_comb
    begin
        case (state_reg)
            pmsc_pkg::ST_PIV_RD:
                wk_ra = wk_addr(perm_reg[p_reg[MW-1:0]], k_reg);
            pmsc_pkg::ST_OP_RD:
            begin
                case (op_reg)
                    2'd0:    wk_ra = wk_addr(perm_reg[i_reg[MW-1:0]], j_reg);
                    2'd1:    wk_ra = wk_addr(perm_reg[i_reg[MW-1:0]], k_reg);
                    default: wk_ra = wk_addr(perm_reg[k_reg[MW-1:0]], j_reg);
                endcase
            end
            default:
                wk_ra = wk_addr(perm_reg[sz_m1[MW-1:0]], sz_m1);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wk_we)
            work_mem[wk_wa] <= wk_wd;
        wk_rd_reg <= work_mem[wk_ra];
    end

    // ------------------------------------------------------------------
    // Shared multiplier (32x32, registered) and divider step
    // ------------------------------------------------------------------
    always_comb
    begin
        mx  = mcnt_reg[2] ? opb_reg : opa_reg;
        my  = mcnt_reg[2] ? opc_reg : pivot_reg;
        mxm = mx[VW-1] ? (~mx + VW'(1)) : mx;
        mym = my[VW-1] ? (~my + VW'(1)) : my;
        mxh = mcnt_reg[0] ? mxm[VW-1:HW] : mxm[HW-1:0];
        myh = mcnt_reg[1] ? mym[VW-1:HW] : mym[HW-1:0];
        case (pp_sh_reg)
            2'd0:    term = {{(NW-2*HW){1'b0}}, pp_reg};
            2'd1:    term = {{(NW-3*HW){1'b0}}, pp_reg, {HW{1'b0}}};
            default: term = {pp_reg, {(NW-2*HW){1'b0}}};
        endcase
        acc_next = pp_neg_reg ? (acc_reg - term) : (acc_reg + term);
        nmag     = acc_reg[NW-1] ? (~acc_reg + NW'(1)) : acc_reg;
        dsh      = {rem_reg, quo_reg[VW-1]};
        dge      = (dsh >= {1'b0, dmag_reg});
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmsc_pkg::ST_IDLE:
                if (accept && last_entry)
                    state_next = pmsc_pkg::ST_SIZE;
            pmsc_pkg::ST_SIZE:
                state_next = size_ok ? pmsc_pkg::ST_LOAD : pmsc_pkg::ST_DONE;
            pmsc_pkg::ST_LOAD:
                if ((li_reg == sz_m1) && (lj_reg == sz_m1))
                    state_next = pmsc_pkg::ST_DRAIN;
            pmsc_pkg::ST_DRAIN:
                state_next = (sz_reg == SW'(1)) ? pmsc_pkg::ST_LAST_RD : pmsc_pkg::ST_PIV_RD;
            pmsc_pkg::ST_PIV_RD:
                state_next = pmsc_pkg::ST_PIV_CHK;
            pmsc_pkg::ST_PIV_CHK:
            begin
                if (wk_rd_reg != '0)
                    state_next = pmsc_pkg::ST_OP_RD;
                else if (p_reg == sz_m1)
                    state_next = pmsc_pkg::ST_NEXT;
                else
                    state_next = pmsc_pkg::ST_PIV_RD;
            end
            pmsc_pkg::ST_OP_RD:
                if (op_reg == 2'd3)
                    state_next = pmsc_pkg::ST_MUL;
            pmsc_pkg::ST_MUL:
                if (mcnt_reg == pmsc_pkg::MUL_LAST)
                    state_next = pmsc_pkg::ST_DIV_INIT;
            pmsc_pkg::ST_DIV_INIT:
                state_next = (k_reg == '0) ? pmsc_pkg::ST_WRITE : pmsc_pkg::ST_DIV;
            pmsc_pkg::ST_DIV:
                if (dcnt_reg == '1)
                    state_next = pmsc_pkg::ST_DIV_END;
            pmsc_pkg::ST_DIV_END:
                state_next = pmsc_pkg::ST_WRITE;
            pmsc_pkg::ST_WRITE:
            begin
                if (!(last_j && last_i))
                    state_next = pmsc_pkg::ST_OP_RD;
                else if ((k_reg + SW'(2)) == sz_reg)
                    state_next = pmsc_pkg::ST_LAST_RD;
                else
                    state_next = pmsc_pkg::ST_PIV_RD;
            end
            pmsc_pkg::ST_LAST_RD:
                state_next = pmsc_pkg::ST_LAST_CHK;
            pmsc_pkg::ST_LAST_CHK:
                if ((wk_rd_reg != '0) && (wk_rd_reg[VW-1] != swap_reg))
                    state_next = pmsc_pkg::ST_DONE;
                else
                    state_next = pmsc_pkg::ST_NEXT;
            pmsc_pkg::ST_NEXT:
                state_next = nx_any ? pmsc_pkg::ST_LOAD : pmsc_pkg::ST_SIZE;
            pmsc_pkg::ST_DONE:
                state_next = pmsc_pkg::ST_IDLE;
            default:
                state_next = pmsc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy           = (state_reg != pmsc_pkg::ST_IDLE);
        done           = (state_reg == pmsc_pkg::ST_DONE);
        negative_found = flag_reg;
        cfg_ready      = 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pmsc_pkg::ST_IDLE;
            dim_reg      <= pmsc_pkg::DIMENSION_RST;
            minor_reg    <= pmsc_pkg::LARGEST_MINOR_RST;
            sz_reg       <= '0;
            li_reg       <= '0;
            lj_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            p_reg        <= '0;
            op_reg       <= '0;
            mcnt_reg     <= '0;
            dcnt_reg     <= '0;
            swap_reg     <= 1'b0;
            flag_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            for (int t = 0; t < MAX_MINOR; t++)
                sub_reg[t] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= (state_reg == pmsc_pkg::ST_LOAD);

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == pmsc_pkg::CFG_DIMENSION)
                    dim_reg <= cfg_data;
                else if (cfg_index == pmsc_pkg::CFG_LARGEST_MINOR)
                    minor_reg <= cfg_data[pmsc_pkg::MINOR_W-1:0];
            end

            case (state_reg)
                pmsc_pkg::ST_IDLE:
                    sz_reg <= SW'(1);
                pmsc_pkg::ST_SIZE:
                begin
                    li_reg <= '0;
                    lj_reg <= '0;
                    if (size_ok)
                    begin
                        for (int t = 0; t < MAX_MINOR; t++)
                            sub_reg[t] <= IDX_W'(t);
                    end
                    else
                        flag_reg <= 1'b0;
                end
                pmsc_pkg::ST_LOAD:
                begin
                    if (lj_reg == sz_m1)
                    begin
                        lj_reg <= '0;
                        li_reg <= li_reg + SW'(1);
                    end
                    else
                        lj_reg <= lj_reg + SW'(1);
                end
                pmsc_pkg::ST_DRAIN:
                begin
                    k_reg    <= '0;
                    p_reg    <= '0;
                    swap_reg <= 1'b0;
                end
                pmsc_pkg::ST_PIV_CHK:
                begin
                    op_reg <= '0;
                    i_reg  <= k_reg + SW'(1);
                    j_reg  <= k_reg + SW'(1);
                    if (wk_rd_reg != '0)
                    begin
                        if (p_reg != k_reg)
                            swap_reg <= !swap_reg;
                    end
                    else
                        p_reg <= p_reg + SW'(1);
                end
                pmsc_pkg::ST_OP_RD:
                begin
                    op_reg   <= op_reg + 2'd1;
                    mcnt_reg <= '0;
                end
                pmsc_pkg::ST_MUL:
                    mcnt_reg <= mcnt_reg + pmsc_pkg::MCNT_W'(1);
                pmsc_pkg::ST_DIV_INIT:
                    dcnt_reg <= '0;
                pmsc_pkg::ST_DIV:
                    dcnt_reg <= dcnt_reg + pmsc_pkg::DCNT_W'(1);
                pmsc_pkg::ST_WRITE:
                begin
                    op_reg <= '0;
                    if (!last_j)
                        j_reg <= j_reg + SW'(1);
                    else if (!last_i)
                    begin
                        i_reg <= i_reg + SW'(1);
                        j_reg <= k_reg + SW'(1);
                    end
                    else
                    begin
                        k_reg <= k_reg + SW'(1);
                        p_reg <= k_reg + SW'(1);
                    end
                end
                pmsc_pkg::ST_LAST_CHK:
                    if ((wk_rd_reg != '0) && (wk_rd_reg[VW-1] != swap_reg))
                        flag_reg <= 1'b1;
                pmsc_pkg::ST_NEXT:
                begin
                    li_reg <= '0;
                    lj_reg <= '0;
                    if (nx_any)
                    begin
                        for (int t = 0; t < MAX_MINOR; t++)
                            sub_reg[t] <= nx_sub[t];
                    end
                    else
                        sz_reg <= sz_reg + SW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= wk_addr(li_reg[MW-1:0], lj_reg);
        case (state_reg)
            pmsc_pkg::ST_DRAIN:
            begin
                prev_reg <= VW'(1);
                for (int t = 0; t < MAX_MINOR; t++)
                    perm_reg[t] <= MW'(t);
            end
            pmsc_pkg::ST_PIV_CHK:
                if (wk_rd_reg != '0)
                begin
                    pivot_reg <= wk_rd_reg;
                    if (p_reg != k_reg)
                    begin
                        perm_reg[p_reg[MW-1:0]] <= perm_reg[k_reg[MW-1:0]];
                        perm_reg[k_reg[MW-1:0]] <= perm_reg[p_reg[MW-1:0]];
                    end
                end
            pmsc_pkg::ST_OP_RD:
            begin
                acc_reg <= '0;
                case (op_reg)
                    2'd1:    opa_reg <= wk_rd_reg;
                    2'd2:    opb_reg <= wk_rd_reg;
                    2'd3:    opc_reg <= wk_rd_reg;
                    default: ;
                endcase
            end
            pmsc_pkg::ST_MUL:
            begin
                if (mcnt_reg != '0)
                    acc_reg <= acc_next;
                pp_reg     <= (2*HW)'(mxh) * (2*HW)'(myh);
                pp_sh_reg  <= {1'b0, mcnt_reg[0]} + {1'b0, mcnt_reg[1]};
                pp_neg_reg <= mx[VW-1] ^ my[VW-1] ^ mcnt_reg[2];
            end
            pmsc_pkg::ST_DIV_INIT:
            begin
                res_reg  <= acc_reg[VW-1:0];
                rem_reg  <= nmag[NW-1:VW];
                quo_reg  <= nmag[VW-1:0];
                dmag_reg <= prev_reg[VW-1] ? (~prev_reg + VW'(1)) : prev_reg;
                qneg_reg <= acc_reg[NW-1] ^ prev_reg[VW-1];
            end
            pmsc_pkg::ST_DIV:
            begin
                rem_reg <= dge ? VW'(dsh - {1'b0, dmag_reg}) : dsh[VW-1:0];
                quo_reg <= {quo_reg[VW-2:0], dge};
            end
            pmsc_pkg::ST_DIV_END:
                res_reg <= qneg_reg ? (~quo_reg + VW'(1)) : quo_reg;
            pmsc_pkg::ST_WRITE:
                if (last_j && last_i)
                    prev_reg <= pivot_reg;
            default:
            begin
            end
        endcase
    end

`ifndef SYNTH
    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result strobe");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_vld_reg && (state_reg == pmsc_pkg::ST_WRITE)))
        else $error("work RAM fill collides with element write");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pmsc_pkg::ST_DIV) |-> (dmag_reg != '0))
        else $error("division by zero pivot");

    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_entry) |=> busy)
        else $error("last word did not start the search");
`endif

endmodule

`default_nettype wire

/* test/principal_minor_sign_check_top_tb.sv */
// Testbench for principal_minor_sign_check_top: loads matrices, sweeps register settings,
// and checks each negative-minor flag against a built-in Bareiss predictor.
// Depends on pmsc_pkg and principal_minor_sign_check_top.
`default_nettype none

// Keeps a shadow copy of the matrix and registers, predicts the flag for every
// word that carries last_entry, and compares it with what the block reports.
class minor_sign_board;
    logic signed [7:0] store [32][32];
    int dimension_reg;
    int largest_reg;
    bit flags_due [$];
    int mismatches;
    int unexpected;
    int flags_checked;
    int flags_set;

    function new();
        dimension_reg = 32;
        largest_reg   = 5;
        mismatches    = 0;
        unexpected    = 0;
        flags_checked = 0;
        flags_set     = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [5:0] data);
        if (idx == pmsc_pkg::CFG_DIMENSION)
            dimension_reg = data;
        else if (idx == pmsc_pkg::CFG_LARGEST_MINOR)
            largest_reg = data[2:0];
    endfunction

    // Fraction-free elimination of one principal submatrix; true if det < 0.
    function bit submatrix_negative(int sz, int sel [5]);
        longint w [5][5];
        longint tmp;
        logic signed [127:0] a, b, c, d, num, prev;
        bit flip;
        int p;
        for (int i = 0; i < sz; i++)
            for (int j = 0; j < sz; j++)
                w[i][j] = store[sel[i]][sel[j]];
        flip = 0;
        prev = 1;
        for (int k = 0; k + 1 < sz; k++)
        begin
            p = k;
            while (p < sz && w[p][k] == 0)
                p++;
            if (p == sz)
                return 0;
            if (p != k)
            begin
                for (int j = 0; j < sz; j++)
                begin
                    tmp = w[p][j];
                    w[p][j] = w[k][j];
                    w[k][j] = tmp;
                end
                flip = !flip;
            end
            for (int i = k + 1; i < sz; i++)
                for (int j = k + 1; j < sz; j++)
                begin
                    a = w[i][j];
                    b = w[k][k];
                    c = w[i][k];
                    d = w[k][j];
                    num = a * b - c * d;
                    num = num / prev;
                    w[i][j] = longint'(num[63:0]);
                end
            prev = w[k][k];
        end
        if (w[sz-1][sz-1] == 0)
            return 0;
        return (w[sz-1][sz-1] < 0) != flip;
    endfunction

    function bit any_minor_negative();
        int n, top, t;
        int sel [5];
        n   = dimension_reg > 32 ? 32 : dimension_reg;
        top = largest_reg > 5 ? 5 : largest_reg;
        for (int sz = 1; sz <= top && sz <= n; sz++)
        begin
            for (int i = 0; i < sz; i++)
                sel[i] = i;
            forever
            begin
                if (submatrix_negative(sz, sel))
                    return 1;
                t = sz - 1;
                while (t >= 0 && sel[t] == n - sz + t)
                    t--;
                if (t < 0)
                    break;
                sel[t]++;
                for (int j = t + 1; j < sz; j++)
                    sel[j] = sel[j-1] + 1;
            end
        end
        return 0;
    endfunction

    function void note_word(logic [4:0] row, logic [4:0] col, logic signed [7:0] value,
                            logic last);
        store[row][col] = value;
        if (last)
            flags_due.insert(flags_due.size(), any_minor_negative());
    endfunction

    function void check_result(logic flag);
        bit want;
        if (flags_due.size() == 0)
        begin
            unexpected++;
            if (mismatches + unexpected <= 10)
                $display("unexpected result word: negative_found=%0b", flag);
            return;
        end
        want = flags_due.pop_front();
        flags_checked++;
        if (want)
            flags_set++;
        if (flag !== want)
        begin
            mismatches++;
            if (mismatches + unexpected <= 10)
                $display("negative_found mismatch: expected %0b, got %0b", want, flag);
        end
    endfunction

    function int pending();
        return flags_due.size();
    endfunction
endclass

module principal_minor_sign_check_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 400000;    // idle cycles tolerated with nothing accepted

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [4:0] row_index;
    logic [4:0] column_index;
    logic signed [7:0] entry_value;
    logic last_entry;
    logic done;
    logic negative_found;
    logic cfg_valid;
    logic cfg_ready;
    logic [pmsc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pmsc_pkg::CFG_DATA_W-1:0] cfg_data;

    minor_sign_board board;
    int words_sent;
    int searches;
    int stall_cycles;

    principal_minor_sign_check_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .row_index      (row_index),
        .column_index   (column_index),
        .entry_value    (entry_value),
        .last_entry     (last_entry),
        .done           (done),
        .negative_found (negative_found),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Monitor: every handshake is seen with pre-edge values, so the order of
    // events inside the edge does not matter. The watchdog rides along here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                board.note_word(row_index, column_index, entry_value, last_entry);
            if (done)
                board.check_result(negative_found);
            if (cfg_valid && cfg_ready)
                board.write_register(cfg_index, cfg_data);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("[principal_minor_sign_check_top] ERROR");
                $finish;
            end
        end
    end

    // Gap after a word: mostly none, sometimes short, rarely a long one.
    task automatic idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return;
        start <= 1'b0;
        if (r < 92)
            repeat ($urandom_range(1, 3)) @(posedge clk);
        else
            repeat ($urandom_range(5, 30)) @(posedge clk);
    endtask

    // Offer one matrix word and hold it until the block takes it.
    task automatic send_word(int row, int col, int value, bit last);
        start        <= 1'b1;
        row_index    <= row[4:0];
        column_index <= col[4:0];
        entry_value  <= value[7:0];
        last_entry   <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        if (last)
            searches++;
        idle_gap();
    endtask

    // Registers change only once every flag is in and the block is quiet.
    task automatic write_register(logic [1:0] idx, int value);
        start <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[5:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_shape(int dim, int largest);
        write_register(pmsc_pkg::CFG_DIMENSION, dim);
        write_register(pmsc_pkg::CFG_LARGEST_MINOR, largest);
    endtask

    // Entry styles: 0 full random, 1 diagonally dominant (no negative minor),
    // 2 dominant with one off-diagonal pair pushed to 127 or -128, each cell drawn apart, so a
    // 2x2 minor may turn negative, 3 sparse in {-1,0,1} so zero pivots and row swaps show up.
    function automatic int pick_entry(int style, int i, int j, int bad_i, int bad_j);
        case (style)
            0: return $urandom_range(0, 255) - 128;
            1, 2:
            begin
                if (i == j)
                    return $urandom_range(100, 127);
                if (style == 2 && ((i == bad_i && j == bad_j) || (i == bad_j && j == bad_i)))
                    return $urandom_range(0, 1) ? 127 : -128;
                return $urandom_range(0, 40) - 20;
            end
            default: return $urandom_range(0, 2) - 1;
        endcase
    endfunction

    // Loads the n x n block (or only its diagonal) and fires a search on the last word.
    task automatic load_and_search(int n, bit diag_only, int style);
        int bad_i, bad_j;
        bad_i = $urandom_range(0, n - 1);
        bad_j = (bad_i + 1 + $urandom_range(0, n > 1 ? n - 2 : 0)) % n;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (!diag_only || i == j)
                    send_word(i, j, pick_entry(style, i, j, bad_i, bad_j),
                              i == n - 1 && j == n - 1);
    endtask

    int pick;
    int dim;
    int top;

    initial
    begin
        board        = new();
        words_sent   = 0;
        searches     = 0;
        stall_cycles = 0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        row_index    <= '0;
        column_index <= '0;
        entry_value  <= '0;
        last_entry   <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme entries, a negative 1x1 minor found late in the sweep.
        set_shape(3, 3);
        send_word(0, 0, 127, 0);
        send_word(0, 1, -128, 0);
        send_word(0, 2, 0, 0);
        send_word(1, 0, -128, 0);
        send_word(1, 1, 127, 0);
        send_word(1, 2, 1, 0);
        send_word(2, 0, 0, 0);
        send_word(2, 1, 1, 0);
        send_word(2, 2, -1, 1);
        // Zero diagonal: the 2x2 minor needs a row swap and comes out negative.
        send_word(2, 2, 0, 0);
        send_word(0, 0, 0, 0);
        send_word(1, 1, 0, 0);
        send_word(0, 1, 1, 0);
        send_word(1, 0, 1, 1);
        // A sparse search, then all zero: every pivot column is empty, flag stays low.
        load_and_search(3, 0, 3);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                send_word(i, j, 0, i == 2 && j == 2);

        // Register extremes and clamping.
        set_shape(32, 1);
        load_and_search(32, 1, 1);
        set_shape(63, 1);
        load_and_search(32, 1, 0);
        set_shape(0, 3);
        send_word(31, 31, -128, 1);
        set_shape(3, 0);
        send_word(2, 1, 5, 1);
        set_shape(6, 7);
        load_and_search(6, 0, 1);
        set_shape(5, 5);
        load_and_search(5, 0, 2);
        set_shape(2, 6);
        load_and_search(2, 0, 0);
        set_shape(1, 1);
        load_and_search(1, 0, 0);

        // Random: small shapes, several full loads each; most are well formed
        // dominant matrices so the sweep runs deep before any flag.
        while (words_sent < 850)
        begin
            dim = $urandom_range(1, 5);
            top = $urandom_range(0, 9) == 0 ? $urandom_range(0, 7) : $urandom_range(1, 5);
            set_shape(dim, top);
            repeat ($urandom_range(2, 5))
            begin
                pick = $urandom_range(0, 99);
                load_and_search(dim, 0, pick < 35 ? 1 : pick < 60 ? 2 : pick < 85 ? 0 : 3);
                // stray rewrites of random cells between searches
                repeat ($urandom_range(0, 3))
                    send_word($urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 255) - 128, 0);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d words loaded, %0d minor searches, %0d flags checked (%0d set)",
                 words_sent, searches, board.flags_checked, board.flags_set);
        $display("%0d mismatches, %0d unexpected results", board.mismatches, board.unexpected);
        if (board.mismatches == 0 && board.unexpected == 0)
            $display("[principal_minor_sign_check_top] OK");
        else
            $display("[principal_minor_sign_check_top] ERROR");
        $finish;
    end
endmodule

`default_nettype wire
